// ----- rtl/half_precision_adder_macros.svh -----
// Assertion macros used by the checker file.
`ifndef HALF_PRECISION_ADDER_MACROS_SVH
`define HALF_PRECISION_ADDER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define HPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define HPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpa_pkg.sv -----
package hpa_pkg;

    localparam logic [15:0] INF_BITS  = 16'h7c00;
    localparam logic [9:0]  FRAC_MASK = 10'h3ff;

    // Count of leading zeros over a 14-bit magnitude (bit 13 is the lead position).
    function automatic logic [3:0] lzc14(input logic [13:0] v);
        logic [3:0] n;
        logic       hit;
        n   = 4'd14;
        hit = 1'b0;
        for (int i = 13; i >= 0; i--) begin
            if (!hit && v[i]) begin
                n   = 4'(13 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/half_precision_adder.sv -----
// Registered stages in order: align, add or subtract, normalize, round and pack.
// Throughput: one operand pair per cycle; the pipeline advances whenever the
// output stage is empty or its result is being taken.
// Reset: i_rst_n synchronous, active low, clears all stage valid bits; data
// registers are not reset.
module half_precision_adder
    import hpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_addend_a,
    input  logic [15:0] i_addend_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_sum_bits
);

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4;

    assign adv     = !r_v4 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v4;

    // ---------------- stage 1: order and align ----------------
    logic        s1_y_leads;
    logic [15:0] s1_a, s1_b;
    logic [4:0]  s1_af, s1_bf, s1_aex, s1_bex, s1_shift;
    logic [13:0] s1_wa, s1_wb0, s1_wb, s1_lostmask;
    logic        s1_inf;

    always_comb begin
        s1_y_leads  = i_addend_b[14:10] > i_addend_a[14:10];
        s1_a        = s1_y_leads ? i_addend_b : i_addend_a;
        s1_b        = s1_y_leads ? i_addend_a : i_addend_b;
        s1_af       = s1_a[14:10];
        s1_bf       = s1_b[14:10];
        s1_aex      = (s1_af != 5'd0) ? s1_af : 5'd1;
        s1_bex      = (s1_bf != 5'd0) ? s1_bf : 5'd1;
        s1_shift    = s1_aex - s1_bex;
        s1_wa       = {(s1_af != 5'd0), s1_a[9:0], 3'b000};
        s1_wb0      = {(s1_bf != 5'd0), s1_b[9:0], 3'b000};
        s1_inf      = (s1_af == 5'd31) && (s1_a[9:0] == 10'd0);
        s1_lostmask = 14'h0;
        if (s1_shift >= 5'd14) begin
            s1_wb = {13'd0, (s1_wb0 != 14'd0)};
        end else begin
            s1_lostmask = ~(14'h3fff << s1_shift);
            s1_wb = (s1_wb0 >> s1_shift) | {13'd0, ((s1_wb0 & s1_lostmask) != 14'd0)};
        end
    end

    logic [13:0] r_wa, r_wb;
    logic        r_as, r_bs, r_inf1;
    logic [4:0]  r_ex1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
        if (adv) begin
            r_wa   <= s1_wa;
            r_wb   <= s1_wb;
            r_as   <= s1_a[15];
            r_bs   <= s1_b[15];
            r_inf1 <= s1_inf;
            r_ex1  <= s1_aex;
        end
    end

    // ---------------- stage 2: add or subtract magnitudes ----------------
    logic [14:0] s2_z;
    logic        s2_sign;

    always_comb begin
        if (r_as != r_bs) begin
            if (r_wa > r_wb) begin
                s2_z    = {1'b0, r_wa - r_wb};
                s2_sign = r_as;
            end else begin
                s2_z    = {1'b0, r_wb - r_wa};
                s2_sign = r_bs;
            end
        end else begin
            s2_z    = {1'b0, r_wa} + {1'b0, r_wb};
            s2_sign = r_as;
        end
    end

    logic [14:0] r_z2;
    logic        r_sign2, r_inf2, r_zero2;
    logic [4:0]  r_ex2;
    logic [15:0] r_infbits2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
        if (adv) begin
            r_z2       <= s2_z;
            r_sign2    <= s2_sign;
            r_inf2     <= r_inf1;
            r_infbits2 <= {r_as, 15'h0} | INF_BITS;
            r_zero2    <= (r_as != r_bs) && (s2_z == 15'd0);
            r_ex2      <= r_ex1;
        end
    end

    // ---------------- stage 3: normalize ----------------
    logic [3:0]  s3_lz, s3_sh;
    logic [13:0] s3_z;
    logic [5:0]  s3_e;

    always_comb begin
        s3_lz = lzc14(r_z2[13:0]);
        s3_sh = 4'd0;
        if (r_z2[14]) begin
            s3_z = r_z2[14:1] | {13'd0, r_z2[0]};
            s3_e = {1'b0, r_ex2} + 6'd1;
        end else begin
            // stop the shift at the smallest exponent
            if ({1'b0, s3_lz} < r_ex2) begin
                s3_sh = s3_lz;
            end else begin
                s3_sh = 4'(r_ex2 - 5'd1);
            end
            s3_z = r_z2[13:0] << s3_sh;
            s3_e = {1'b0, r_ex2} - {2'b00, s3_sh};
        end
    end

    logic [13:0] r_z3;
    logic [5:0]  r_e3;
    logic        r_sign3, r_inf3, r_zero3;
    logic [15:0] r_infbits3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_z3       <= s3_z;
            r_e3       <= s3_e;
            r_sign3    <= r_sign2;
            r_inf3     <= r_inf2;
            r_zero3    <= r_zero2;
            r_infbits3 <= r_infbits2;
        end
    end

    // ---------------- stage 4: round and pack ----------------
    logic [14:0] s4_z;
    logic [5:0]  s4_e;
    logic [10:0] s4_m;
    logic [15:0] n_sum;

    always_comb begin
        s4_z = {1'b0, r_z3} + 15'd4;
        s4_e = r_e3;
        if (s4_z[14]) begin
            s4_z = s4_z >> 1;
            s4_e = r_e3 + 6'd1;
        end
        s4_m = s4_z[13:3];
        if (r_inf3) begin
            n_sum = r_infbits3;
        end else if (r_zero3) begin
            n_sum = 16'h0000;
        end else if (s4_e >= 6'd31) begin
            n_sum = {r_sign3, 15'h0} | INF_BITS;
        end else begin
            n_sum = {r_sign3, (s4_m[10] ? s4_e[4:0] : 5'd0), s4_m[9:0] & FRAC_MASK};
        end
    end

    logic [15:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= r_v3;
        end
        if (adv) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_bits = r_sum;

endmodule

// ----- rtl/hpa_checker.sv -----
`include "half_precision_adder_macros.svh"

module hpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_sum_bits
);

    // a stalled result must hold
    `HPA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sum_bits), "hold")
    // the pipeline only stalls when the output is full and blocked
    `HPA_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "ready dropped")
    // an empty output stage accepts
    `HPA_ASSERT_IMP(a_empty, i_clk, i_rst_n, !o_valid, o_ready, "ready low while output empty")
    // no result is left over from before reset
    `HPA_ASSERT_IMP(a_novalid, i_clk, i_rst_n, !$past(i_rst_n), !o_valid, "result after reset")

endmodule

bind half_precision_adder hpa_checker u_hpa_checker (.*);
